[design/nsc_pkg.sv]
`default_nettype none
package nsc_pkg;

  localparam int TEXT_W = 8;
  localparam int FNUM_W = 5;

  typedef logic [TEXT_W-1:0] text_t;
  typedef logic [FNUM_W-1:0] fnum_t;

  // One result item as it leaves the parser
  typedef struct packed {
    fnum_t field_number;
    logic  field_byte_valid;
    logic  field_closed;
    logic  sentence_done;
    logic  marker_seen;
    logic  checksum_match;
    fnum_t fields_total;
  } res_t;

endpackage
`default_nettype wire

[design/nsc_in_if.sv]
`default_nettype none
interface nsc_in_if;
  logic                valid;
  logic                ready;
  nsc_pkg::text_t      text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

[design/nsc_out_if.sv]
`default_nettype none
interface nsc_out_if;
  logic           valid;
  logic           ready;
  nsc_pkg::fnum_t field_number;
  logic           field_byte_valid;
  logic           field_closed;
  logic           sentence_done;
  logic           marker_seen;
  logic           checksum_match;
  nsc_pkg::fnum_t fields_total;

  modport source (
    output valid, output field_number, output field_byte_valid, output field_closed,
    output sentence_done, output marker_seen, output checksum_match,
    output fields_total, input ready
  );
  modport sink (
    input valid, input field_number, input field_byte_valid, input field_closed,
    input sentence_done, input marker_seen, input checksum_match,
    input fields_total, output ready
  );
endinterface
`default_nettype wire

[design/nsc_in_stage.sv]
`default_nettype none
module nsc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire nsc_pkg::text_t in_byte,
  input  wire logic           take,
  output logic                hold_valid,
  output nsc_pkg::text_t      hold_byte
);
  import nsc_pkg::*;

  logic  valid_r, valid_nxt;
  text_t byte_r;

  // stage frees up in the same cycle its byte moves on
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;
endmodule
`default_nettype wire

[design/nsc_parser.sv]
`default_nettype none
module nsc_parser #(
  parameter int FIELD_LIMIT = 20
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire nsc_pkg::text_t c,
  output nsc_pkg::res_t       res
);
  import nsc_pkg::*;

  localparam text_t CH_STAR  = text_t'(8'h2A);
  localparam text_t CH_COMMA = text_t'(8'h2C);
  localparam text_t CH_NUL   = text_t'(8'h00);
  localparam logic [FNUM_W:0] LIMIT = (FNUM_W+1)'(FIELD_LIMIT);

  typedef enum logic [1:0] {
    PH_BODY = 2'd0,
    PH_HEX  = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  logic [TEXT_W-1:0] xor_r, xor_nxt;
  fnum_t             field_r, field_nxt;
  logic              halted_r, halted_nxt;
  phase_t            phase_r, phase_nxt;
  logic [TEXT_W-1:0] rsum_r, rsum_nxt;

  logic              hex_ok;
  logic [3:0]        hex_val;
  logic [FNUM_W:0]   field_inc;
  logic              marker;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign field_inc = {1'b0, field_r} + (FNUM_W+1)'(1);
  assign marker    = (phase_r != PH_BODY);

  always_comb begin
    xor_nxt    = xor_r;
    field_nxt  = field_r;
    halted_nxt = halted_r;
    phase_nxt  = phase_r;
    rsum_nxt   = rsum_r;

    res                  = '0;
    res.field_number     = field_r;

    if (c == CH_NUL) begin
      res.sentence_done  = 1'b1;
      res.field_closed   = (phase_r == PH_BODY) && !halted_r;
      res.marker_seen    = marker;
      res.checksum_match = marker && (xor_r == rsum_r);
      res.fields_total   = field_inc[FNUM_W-1:0];
      xor_nxt    = '0;
      field_nxt  = '0;
      halted_nxt = 1'b0;
      phase_nxt  = PH_BODY;
      rsum_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_BODY: begin
          if (c == CH_STAR) begin
            res.field_closed = !halted_r;
            phase_nxt        = PH_HEX;
            rsum_nxt         = '0;
          end else begin
            xor_nxt = xor_r ^ c;
            if (!halted_r) begin
              if (c == CH_COMMA) begin
                res.field_closed = 1'b1;
                if (field_inc >= LIMIT) begin
                  halted_nxt = 1'b1;
                end else begin
                  field_nxt = field_inc[FNUM_W-1:0];
                end
              end else begin
                res.field_byte_valid = 1'b1;
              end
            end
          end
        end
        PH_HEX: begin
          if (hex_ok) begin
            rsum_nxt = {rsum_r[TEXT_W-5:0], hex_val};
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        // skip phase and the unused code: ignore bytes until the terminator
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r    <= '0;
      field_r  <= '0;
      halted_r <= 1'b0;
      phase_r  <= PH_BODY;
      rsum_r   <= '0;
    end else if (step) begin
      xor_r    <= xor_nxt;
      field_r  <= field_nxt;
      halted_r <= halted_nxt;
      phase_r  <= phase_nxt;
      rsum_r   <= rsum_nxt;
    end
  end
endmodule
`default_nettype wire

[design/nsc_out_stage.sv]
`default_nettype none
module nsc_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire nsc_pkg::res_t res_in,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output nsc_pkg::res_t      res_out
);
  import nsc_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign space     = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;
endmodule
`default_nettype wire

[design/nmea_sentence_checksum_splitter.sv]
// NMEA sentence checksum checker and field splitter.
// in_ch carries one sentence byte per transfer (no leading '$'); a zero byte
// ends the sentence. out_ch returns exactly one result per input byte, in
// order: field number, content/close marks, and on the zero byte the
// done flag, marker-seen flag, checksum match and field count.
// A byte transferred on in_ch passes through the input register, then the
// result register, before its result shows on out_ch.
// Throughput: one byte per clock while out_ch does not stall; the per-byte
// state update (running XOR, field counter, hex accumulator) is a
// combinational step between the two registers.
// When out_ch stalls, the result register holds its item and the input
// register still takes one more byte; in_ch.ready drops only when both
// registers are full.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a sentence. After each zero byte the parser
// returns to that same start state by itself.
// FIELD_LIMIT (1..31) caps the number of fields that are split out.
`default_nettype none
module nmea_sentence_checksum_splitter #(
  parameter int FIELD_LIMIT = 20
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nsc_in_if.sink     in_ch,
  nsc_out_if.source  out_ch
);
  import nsc_pkg::*;

  logic  hold_valid;
  text_t hold_byte;
  logic  space;
  logic  step;
  res_t  res_comb;
  res_t  res_q;

  assign step = hold_valid && space;

  nsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.text_byte),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  nsc_parser #(.FIELD_LIMIT(FIELD_LIMIT)) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .c     (hold_byte),
    .res   (res_comb)
  );

  nsc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res_comb),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_out   (res_q)
  );

  assign out_ch.field_number     = res_q.field_number;
  assign out_ch.field_byte_valid = res_q.field_byte_valid;
  assign out_ch.field_closed     = res_q.field_closed;
  assign out_ch.sentence_done    = res_q.sentence_done;
  assign out_ch.marker_seen      = res_q.marker_seen;
  assign out_ch.checksum_match   = res_q.checksum_match;
  assign out_ch.fields_total     = res_q.fields_total;
endmodule
`default_nettype wire
